// ===== hw/rtl/esd_pkg.sv =====
// ----------------------------------------------------------------------------
// esd_pkg
// Shared types and constants for the escape sequence decoder.
// ----------------------------------------------------------------------------
package esd_pkg;

    localparam int POS_WIDTH_DEF = 16;
    localparam int END_POS_W     = 16;

    localparam logic [7:0] CH_NUL       = 8'h00;
    localparam logic [7:0] CH_BACKSLASH = 8'h5c;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_ONE       = 8'h31;
    localparam logic [7:0] CH_SEVEN     = 8'h37;
    localparam logic [7:0] CH_EIGHT     = 8'h38;
    localparam logic [7:0] CH_NINE      = 8'h39;
    localparam logic [7:0] CH_UP_A      = 8'h41;
    localparam logic [7:0] CH_UP_Z      = 8'h5a;
    localparam logic [7:0] CH_LO_A      = 8'h61;
    localparam logic [7:0] CH_LO_F      = 8'h66;
    localparam logic [7:0] CH_LO_X      = 8'h78;
    localparam logic [7:0] CH_UP_X      = 8'h58;
    localparam logic [7:0] CH_LO_T      = 8'h74;
    localparam logic [7:0] CH_LO_R      = 8'h72;
    localparam logic [7:0] CH_LO_N      = 8'h6e;
    localparam logic [7:0] CH_LO_E      = 8'h65;
    localparam logic [7:0] CH_LO_S      = 8'h73;
    localparam logic [7:0] CH_LO_V      = 8'h76;

    localparam logic [7:0] CTL_TAB   = 8'h09;
    localparam logic [7:0] CTL_CR    = 8'h0d;
    localparam logic [7:0] CTL_LF    = 8'h0a;
    localparam logic [7:0] CTL_ESC   = 8'o033;
    localparam logic [7:0] CTL_SPACE = 8'o040;
    localparam logic [7:0] CTL_FF    = 8'h0c;
    localparam logic [7:0] CTL_VT    = 8'h0b;

    localparam logic [8:0] BYTE_MAX = 9'h0ff;

    typedef struct packed {
        logic [7:0]           data;
        logic                 valid;
        logic                 fin;
        logic                 status;
        logic [END_POS_W-1:0] pos;
        logic                 last;
    } res_t;

endpackage

// ===== hw/rtl/escape_sequence_decoder_core.sv =====
// ----------------------------------------------------------------------------
// escape_sequence_decoder_core
// Decodes backslash escapes in a byte stream, one source byte per item.
// ----------------------------------------------------------------------------
//  channel  direction  handshake             payload
//  in       sink       in_valid/in_ready     source_byte
//  out      source     out_valid/out_ready   out_byte byte_valid finished
//                                            status end_position last
//  cfg      sink       cfg_valid/cfg_ready   terminator_char
//
//  One source item per cycle while in_ready is high; each item is decoded in
//  the cycle it is accepted and its zero, one or two results enter a four-entry
//  result queue. in_ready is high while the queue holds two entries or fewer.
//  A result can leave the queue in the cycle after it is written, at the earliest.
//  Reset clears parse state, the position counter, the queue count and pointers and term_reg.
// ----------------------------------------------------------------------------
module escape_sequence_decoder_core #(
    parameter int POS_WIDTH = esd_pkg::POS_WIDTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [7:0]                   source_byte,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [7:0]                   out_byte,
    output logic                         byte_valid,
    output logic                         finished,
    output logic                         status,
    output logic [esd_pkg::END_POS_W-1:0] end_position,
    output logic                         last,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [7:0]                   terminator_char
);
    import esd_pkg::*;

    localparam logic [1:0] MODE_NORMAL = 2'd0;
    localparam logic [1:0] MODE_ESC    = 2'd1;
    localparam logic [1:0] MODE_ZERO   = 2'd2;
    localparam logic [1:0] MODE_DIGITS = 2'd3;

    localparam int QDEPTH = 4;
    localparam int QAW    = 2;

    logic [7:0]           term_reg;
    logic [1:0]           mode_reg,   mode_next;
    logic                 hex_reg,    hex_next;
    logic [1:0]           left_reg,   left_next;
    logic [8:0]           acc_reg,    acc_next;
    logic                 seen_reg,   seen_next;
    logic [7:0]           letter_reg, letter_next;
    logic [POS_WIDTH-1:0] pos_reg,    pos_next;

    res_t                 queue_reg [QDEPTH];
    logic [QAW-1:0]       wr_reg, rd_reg;
    logic [QAW:0]         count_reg, count_next;

    logic                 accept;
    logic                 pop;
    logic [1:0]           nres;
    res_t                 res0, res1;
    logic                 ended;
    logic [END_POS_W-1:0] end_pos;
    logic [31:0]          pos_wide;

    logic [7:0]           b;
    logic [7:0]           lower;
    logic                 f_fin, f_esc;
    logic                 e_hex, e_seen;
    logic [1:0]           e_left;
    logic [8:0]           e_acc;
    logic [7:0]           e_letter;
    logic                 is_digit;
    logic [3:0]           dval;
    logic [12:0]          acc_mul;
    logic [8:0]           acc_new;
    logic [7:0]           close_val;

    assign accept    = in_valid && in_ready;
    assign in_ready  = (count_reg <= (QAW+1)'(2));
    assign cfg_ready = 1'b1;
    assign out_valid = (count_reg != '0);
    assign pop       = out_valid && out_ready;

    assign out_byte     = queue_reg[rd_reg].data;
    assign byte_valid   = queue_reg[rd_reg].valid;
    assign finished     = queue_reg[rd_reg].fin;
    assign status       = queue_reg[rd_reg].status;
    assign end_position = queue_reg[rd_reg].pos;
    assign last         = queue_reg[rd_reg].last;

    assign pos_wide = 32'(pos_reg);
    assign end_pos  = (pos_wide > 32'h0000_ffff) ? '1 : pos_wide[END_POS_W-1:0];

    assign b     = source_byte;
    assign lower = (b >= CH_UP_A && b <= CH_UP_Z) ? (b + 8'h20) : b;
    assign f_fin = (b == CH_NUL) || (b == term_reg);
    assign f_esc = (b == CH_BACKSLASH);

    // effective digit state: the zero mode behaves as an octal run already holding one digit
    always_comb
    begin
        if (mode_reg == MODE_ZERO)
        begin
            e_hex    = 1'b0;
            e_acc    = '0;
            e_seen   = 1'b1;
            e_left   = 2'd2;
            e_letter = CH_ZERO;
        end
        else
        begin
            e_hex    = hex_reg;
            e_acc    = acc_reg;
            e_seen   = seen_reg;
            e_left   = left_reg;
            e_letter = letter_reg;
        end
    end

    always_comb
    begin
        is_digit = 1'b0;
        dval     = '0;
        if (b >= CH_ZERO && b <= CH_SEVEN)
        begin
            is_digit = 1'b1;
            dval     = 4'(b - CH_ZERO);
        end
        else if (e_hex && b >= CH_EIGHT && b <= CH_NINE)
        begin
            is_digit = 1'b1;
            dval     = 4'(b - CH_ZERO);
        end
        else if (e_hex && lower >= CH_LO_A && lower <= CH_LO_F)
        begin
            is_digit = 1'b1;
            dval     = 4'(lower - CH_LO_A + 8'd10);
        end
    end

    assign acc_mul   = e_hex ? {e_acc, 4'b0000} + 13'(dval)
                             : {1'b0, e_acc, 3'b000} + 13'(dval);
    assign acc_new   = acc_mul[8:0];
    assign close_val = e_seen ? e_acc[7:0] : e_letter;

    always_comb
    begin
        mode_next   = mode_reg;
        hex_next    = hex_reg;
        left_next   = left_reg;
        acc_next    = acc_reg;
        seen_next   = seen_reg;
        letter_next = letter_reg;
        nres        = 2'd0;
        ended       = 1'b0;
        res0        = '0;
        res1        = '0;

        unique case (mode_reg)
            MODE_NORMAL:
            begin
                if (f_fin)
                begin
                    nres       = 2'd1;
                    res0.fin   = 1'b1;
                    res0.pos   = end_pos;
                    ended      = 1'b1;
                end
                else if (f_esc)
                begin
                    mode_next = MODE_ESC;
                end
                else
                begin
                    nres       = 2'd1;
                    res0.data  = b;
                    res0.valid = 1'b1;
                end
            end
            MODE_ESC:
            begin
                mode_next   = MODE_NORMAL;
                hex_next    = 1'b0;
                left_next   = '0;
                acc_next    = '0;
                seen_next   = 1'b0;
                letter_next = '0;
                nres        = 2'd1;
                res0.valid  = 1'b1;
                if (b == CH_NUL)
                begin
                    res0.valid  = 1'b0;
                    res0.fin    = 1'b1;
                    res0.status = 1'b1;
                    res0.pos    = end_pos;
                    ended       = 1'b1;
                end
                else if (b == CH_LO_T) res0.data = CTL_TAB;
                else if (b == CH_LO_R) res0.data = CTL_CR;
                else if (b == CH_LO_N) res0.data = CTL_LF;
                else if (b == CH_LO_E) res0.data = CTL_ESC;
                else if (b == CH_LO_S) res0.data = CTL_SPACE;
                else if (b == CH_LO_F) res0.data = CTL_FF;
                else if (b == CH_LO_V) res0.data = CTL_VT;
                else if (b == CH_LO_X || b == CH_UP_X)
                begin
                    nres        = 2'd0;
                    res0.valid  = 1'b0;
                    mode_next   = MODE_DIGITS;
                    hex_next    = 1'b1;
                    left_next   = 2'd2;
                    letter_next = b;
                end
                else if (b == CH_ZERO)
                begin
                    nres        = 2'd0;
                    res0.valid  = 1'b0;
                    mode_next   = MODE_ZERO;
                    letter_next = b;
                end
                else if (b >= CH_ONE && b <= CH_SEVEN)
                begin
                    nres        = 2'd0;
                    res0.valid  = 1'b0;
                    mode_next   = MODE_DIGITS;
                    acc_next    = 9'(b - CH_ZERO);
                    seen_next   = 1'b1;
                    left_next   = 2'd2;
                    letter_next = b;
                end
                else
                begin
                    res0.data = b;
                end
            end
            MODE_ZERO, MODE_DIGITS:
            begin
                if (mode_reg == MODE_ZERO && b == CH_LO_X)
                begin
                    mode_next   = MODE_DIGITS;
                    hex_next    = 1'b1;
                    acc_next    = '0;
                    seen_next   = 1'b0;
                    left_next   = 2'd2;
                    letter_next = b;
                end
                else if (is_digit && e_left != 2'd0)
                begin
                    if (acc_new > BYTE_MAX)
                    begin
                        nres        = 2'd1;
                        res0.fin    = 1'b1;
                        res0.status = 1'b1;
                        res0.pos    = end_pos;
                        ended       = 1'b1;
                    end
                    else if (e_left == 2'd1)
                    begin
                        nres       = 2'd1;
                        res0.data  = acc_new[7:0];
                        res0.valid = 1'b1;
                        mode_next  = MODE_NORMAL;
                    end
                    else
                    begin
                        mode_next   = MODE_DIGITS;
                        hex_next    = e_hex;
                        acc_next    = acc_new;
                        seen_next   = 1'b1;
                        left_next   = e_left - 2'd1;
                        letter_next = e_letter;
                    end
                    if (ended || e_left == 2'd1)
                    begin
                        hex_next    = 1'b0;
                        left_next   = '0;
                        acc_next    = '0;
                        seen_next   = 1'b0;
                        letter_next = '0;
                        mode_next   = MODE_NORMAL;
                    end
                end
                else
                begin
                    // escape closed by a non-digit; that byte is then taken as a fresh one
                    nres        = 2'd1;
                    res0.data   = close_val;
                    res0.valid  = 1'b1;
                    mode_next   = MODE_NORMAL;
                    hex_next    = 1'b0;
                    left_next   = '0;
                    acc_next    = '0;
                    seen_next   = 1'b0;
                    letter_next = '0;
                    if (f_fin)
                    begin
                        nres     = 2'd2;
                        res1.fin = 1'b1;
                        res1.pos = end_pos;
                        ended    = 1'b1;
                    end
                    else if (f_esc)
                    begin
                        mode_next = MODE_ESC;
                    end
                    else
                    begin
                        nres       = 2'd2;
                        res1.data  = b;
                        res1.valid = 1'b1;
                    end
                end
            end
            default:
            begin
                mode_next = MODE_NORMAL;
            end
        endcase

        if (nres == 2'd2)
            res1.last = 1'b1;
        else
            res0.last = 1'b1;

        if (ended)
            pos_next = '0;
        else if (pos_reg != '1)
            pos_next = pos_reg + 1'b1;
        else
            pos_next = pos_reg;
    end

    always_comb
    begin
        count_next = count_reg;
        if (accept)
            count_next = count_next + (QAW+1)'(nres);
        if (pop)
            count_next = count_next - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            term_reg   <= '0;
            mode_reg   <= MODE_NORMAL;
            hex_reg    <= 1'b0;
            left_reg   <= '0;
            acc_reg    <= '0;
            seen_reg   <= 1'b0;
            letter_reg <= '0;
            pos_reg    <= '0;
            wr_reg     <= '0;
            rd_reg     <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                term_reg <= terminator_char;
            if (accept)
            begin
                mode_reg   <= mode_next;
                hex_reg    <= hex_next;
                left_reg   <= left_next;
                acc_reg    <= acc_next;
                seen_reg   <= seen_next;
                letter_reg <= letter_next;
                pos_reg    <= pos_next;
                wr_reg     <= wr_reg + QAW'(nres);
            end
            if (pop)
                rd_reg <= rd_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && nres != 2'd0)
            queue_reg[wr_reg] <= res0;
        if (accept && nres == 2'd2)
            queue_reg[wr_reg + 1'b1] <= res1;
    end

endmodule

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Bench for escape_sequence_decoder_core. Source items are driven with random
// gaps and results are taken with random stalls. Each accepted source item runs
// through a local decoder model, whose results are queued and compared field
// by field with the results leaving the block. Directed strings cover the simple
// escapes, some edge forms and the error cases. Random strings run under several
// terminators.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

    import esd_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int PHASE_ITEMS = 360;

    typedef enum logic [1:0] {
        MODE_PLAIN,
        MODE_BSLASH,
        MODE_ZERO_SEEN,
        MODE_NUMBER
    } decode_mode_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  source_byte;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic        finished;
    logic        status;
    logic [END_POS_W-1:0] end_position;
    logic        last;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  terminator_char;

    // decoder model state
    decode_mode_t mode;
    logic         hex_sel;
    logic [1:0]   digits_left;
    logic [8:0]   acc;
    logic         digit_seen;
    logic [7:0]   esc_letter;
    logic [15:0]  str_pos;
    logic         str_ended;
    logic [7:0]   term_q;

    res_t step_res[$];
    res_t decoded_q[$];

    int  err_count;
    int  items_sent;
    int  idle_cycles;
    bit  idle_on;

    escape_sequence_decoder_core u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .source_byte    (source_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_byte       (out_byte),
        .byte_valid     (byte_valid),
        .finished       (finished),
        .status         (status),
        .end_position   (end_position),
        .last           (last),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .terminator_char(terminator_char)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // ------------------------------------------------------------------------
    // decoder model
    // ------------------------------------------------------------------------
    function void clear_escape();
        mode        = MODE_PLAIN;
        hex_sel     = 1'b0;
        digits_left = 2'd0;
        acc         = 9'd0;
        digit_seen  = 1'b0;
        esc_letter  = 8'd0;
    endfunction

    function void push_res(logic [7:0] d, logic v, logic f, logic s, logic [15:0] p);
        res_t r;
        r.data   = d;
        r.valid  = v;
        r.fin    = f;
        r.status = s;
        r.pos    = p;
        r.last   = 1'b0;
        step_res.push_back(r);
    endfunction

    function void end_string(logic s);
        push_res(8'd0, 1'b0, 1'b1, s, str_pos);
        clear_escape();
        str_pos   = 16'd0;
        str_ended = 1'b1;
    endfunction

    function void put_byte(logic [7:0] d);
        push_res(d, 1'b1, 1'b0, 1'b0, 16'd0);
    endfunction

    function void start_number(logic hx, logic [8:0] a, logic seen, logic [1:0] left,
                               logic [7:0] letter);
        mode        = MODE_NUMBER;
        hex_sel     = hx;
        acc         = a;
        digit_seen  = seen;
        digits_left = left;
        esc_letter  = letter;
    endfunction

    function void plain_byte(logic [7:0] b);
        if (b == CH_NUL || b == term_q)
            end_string(1'b0);
        else if (b == CH_BACKSLASH)
            mode = MODE_BSLASH;
        else
            put_byte(b);
    endfunction

    function void number_byte(logic [7:0] b);
        logic [7:0] low;
        logic       is_dig;
        logic [3:0] d;
        logic [7:0] v;
        low    = (b >= CH_UP_A && b <= CH_UP_Z) ? b + 8'h20 : b;
        is_dig = 1'b0;
        d      = 4'd0;
        if (b >= CH_ZERO && b <= CH_SEVEN)
        begin
            is_dig = 1'b1;
            d      = 4'(b - CH_ZERO);
        end
        else if (hex_sel && (b == CH_EIGHT || b == CH_NINE))
        begin
            is_dig = 1'b1;
            d      = 4'(b - CH_ZERO);
        end
        else if (hex_sel && low >= CH_LO_A && low <= CH_LO_F)
        begin
            is_dig = 1'b1;
            d      = 4'(low - CH_LO_A + 8'd10);
        end
        if (is_dig && digits_left != 2'd0)
        begin
            acc = hex_sel ? {acc[4:0], d} : {acc[5:0], d[2:0]};
            if (acc > BYTE_MAX)
            begin
                end_string(1'b1);
                return;
            end
            digit_seen  = 1'b1;
            digits_left = digits_left - 2'd1;
            if (digits_left == 2'd0)
            begin
                v = acc[7:0];
                clear_escape();
                put_byte(v);
            end
        end
        else
        begin
            v = digit_seen ? acc[7:0] : esc_letter;
            clear_escape();
            put_byte(v);
            plain_byte(b);
        end
    endfunction

    function void escape_byte(logic [7:0] b);
        clear_escape();
        case (b)
            CH_NUL:           end_string(1'b1);
            CH_LO_T:          put_byte(CTL_TAB);
            CH_LO_R:          put_byte(CTL_CR);
            CH_LO_N:          put_byte(CTL_LF);
            CH_LO_E:          put_byte(CTL_ESC);
            CH_LO_S:          put_byte(CTL_SPACE);
            CH_LO_F:          put_byte(CTL_FF);
            CH_LO_V:          put_byte(CTL_VT);
            CH_LO_X, CH_UP_X: start_number(1'b1, 9'd0, 1'b0, 2'd2, b);
            CH_ZERO:
            begin
                mode       = MODE_ZERO_SEEN;
                esc_letter = b;
            end
            default:
            begin
                if (b >= CH_ONE && b <= CH_SEVEN)
                    start_number(1'b0, {1'b0, b - CH_ZERO}, 1'b1, 2'd2, b);
                else
                    put_byte(b);
            end
        endcase
    endfunction

    function void decode_source(logic [7:0] b);
        step_res.delete();
        str_ended = 1'b0;
        case (mode)
            MODE_BSLASH: escape_byte(b);
            MODE_ZERO_SEEN:
            begin
                if (b == CH_LO_X)
                begin
                    start_number(1'b1, 9'd0, 1'b0, 2'd2, b);
                end
                else
                begin
                    start_number(1'b0, 9'd0, 1'b1, 2'd2, CH_ZERO);
                    number_byte(b);
                end
            end
            MODE_NUMBER: number_byte(b);
            default:
            begin
                clear_escape();
                plain_byte(b);
            end
        endcase
        if (!str_ended && str_pos != 16'hffff)
            str_pos = str_pos + 16'd1;
        if (step_res.size() > 0)
            step_res[step_res.size() - 1].last = 1'b1;
        foreach (step_res[i])
            decoded_q.push_back(step_res[i]);
    endfunction

    // ------------------------------------------------------------------------
    // driving and checking
    // ------------------------------------------------------------------------
    task report_mismatch(input string what, input logic [31:0] got, input logic [31:0] want);
        if (err_count < 50)
            $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
        err_count++;
    endtask

    task send_item(input logic [7:0] b);
        int gap;
        @(negedge clk);
        gap = idle_on ? $urandom_range(0, 10) : 0;
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid    = 1'b1;
        source_byte = b;
        do @(posedge clk); while (!in_ready);
        decode_source(b);
        items_sent++;
    endtask

    task write_terminator(input logic [7:0] v);
        @(negedge clk);
        in_valid = 1'b0;
        while (decoded_q.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        @(negedge clk);
        cfg_valid       = 1'b1;
        terminator_char = v;
        do @(posedge clk); while (!cfg_ready);
        term_q = v;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    initial
    begin
        int gap;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            gap = idle_on ? $urandom_range(0, 10) : 0;
            if (gap > 0)
            begin
                out_ready = 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ready = 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    always @(posedge clk)
    begin
        res_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (decoded_q.size() == 0)
            begin
                report_mismatch("result with nothing expected", 32'(out_byte), 32'd0);
            end
            else
            begin
                e = decoded_q.pop_front();
                if (out_byte !== e.data)
                    report_mismatch("out_byte", 32'(out_byte), 32'(e.data));
                if (byte_valid !== e.valid)
                    report_mismatch("byte_valid", 32'(byte_valid), 32'(e.valid));
                if (finished !== e.fin)
                    report_mismatch("finished", 32'(finished), 32'(e.fin));
                if (status !== e.status)
                    report_mismatch("status", 32'(status), 32'(e.status));
                if (end_position !== e.pos)
                    report_mismatch("end_position", 32'(end_position), 32'(e.pos));
                if (last !== e.last)
                    report_mismatch("last", 32'(last), 32'(e.last));
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("tb_top: errors");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    function logic [7:0] text_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(1, 255)); while (b == CH_BACKSLASH || b == term_q);
        return b;
    endfunction

    function logic [7:0] hex_char();
        logic [7:0] d;
        d = 8'($urandom_range(0, 15));
        if (d < 8'd10)
            return CH_ZERO + d;
        return ($urandom_range(0, 1) ? CH_LO_A : CH_UP_A) + d - 8'd10;
    endfunction

    task send_fragment();
        int         kind;
        int         n;
        logic [7:0] simple[7];
        kind   = $urandom_range(0, 99);
        simple = '{CH_LO_T, CH_LO_R, CH_LO_N, CH_LO_E, CH_LO_S, CH_LO_F, CH_LO_V};
        if (kind < 40)
        begin
            send_item(text_byte());
        end
        else if (kind < 55)
        begin
            send_item(CH_BACKSLASH);
            if ($urandom_range(0, 4) == 0)
                send_item(8'($urandom_range(0, 255)));
            else
                send_item(simple[$urandom_range(0, 6)]);
        end
        else if (kind < 70)
        begin
            send_item(CH_BACKSLASH);
            case ($urandom_range(0, 2))
                0: send_item(CH_LO_X);
                1: send_item(CH_UP_X);
                default:
                begin
                    send_item(CH_ZERO);
                    send_item($urandom_range(0, 3) == 0 ? CH_UP_X : CH_LO_X);
                end
            endcase
            n = $urandom_range(0, 2);
            repeat (n) send_item(hex_char());
            if ($urandom_range(0, 1))
                send_item(8'($urandom_range(0, 255)));
        end
        else if (kind < 85)
        begin
            send_item(CH_BACKSLASH);
            n = $urandom_range(1, 3);
            repeat (n) send_item(CH_ZERO + 8'($urandom_range(0, 7)));
            if ($urandom_range(0, 1))
                send_item(8'($urandom_range(0, 255)));
        end
        else if (kind < 92)
        begin
            if (term_q != CH_NUL && $urandom_range(0, 1))
                send_item(term_q);
            else
                send_item(CH_NUL);
        end
        else
        begin
            send_item(8'($urandom_range(0, 255)));
        end
    endtask

    task test_simple_escapes();
        logic [7:0] seq[$];
        seq = '{CH_BACKSLASH, CH_LO_T, CH_BACKSLASH, CH_LO_R, CH_BACKSLASH, CH_LO_N,
                CH_BACKSLASH, CH_LO_E, CH_BACKSLASH, CH_LO_S, CH_BACKSLASH, CH_LO_F,
                CH_BACKSLASH, CH_LO_V, 8'hff, CH_NUL};
        foreach (seq[i]) send_item(seq[i]);
    endtask

    task test_escape_edges();
        logic [7:0] seq[$];
        write_terminator(8'h23);
        // hex cut short, bare X, zero then X, escaped terminator, terminator,
        // octal overflow, backslash then NUL
        seq = '{CH_BACKSLASH, CH_LO_X, 8'h34, 8'h47,
                CH_BACKSLASH, CH_UP_X, 8'h7a,
                CH_BACKSLASH, CH_ZERO, CH_UP_X,
                CH_BACKSLASH, 8'h23, 8'h23,
                CH_BACKSLASH, CH_SEVEN, CH_SEVEN, CH_SEVEN,
                CH_BACKSLASH, CH_NUL};
        foreach (seq[i]) send_item(seq[i]);
    endtask

    task test_random_strings();
        logic [7:0] terms[5];
        int         start;
        terms = '{8'hff, CH_BACKSLASH, CH_LO_X, 8'h00, 8'h00};
        terms[3] = 8'($urandom_range(0, 255));
        foreach (terms[p])
        begin
            write_terminator(terms[p]);
            start = items_sent;
            while (items_sent - start < PHASE_ITEMS)
            begin
                if ($urandom_range(0, 99) == 0)
                    idle_on = !idle_on;
                send_fragment();
            end
        end
    endtask

    initial
    begin
        rst_n           = 1'b0;
        in_valid        = 1'b0;
        source_byte     = 8'd0;
        cfg_valid       = 1'b0;
        terminator_char = 8'd0;
        err_count       = 0;
        items_sent      = 0;
        idle_cycles     = 0;
        idle_on         = 1'b1;
        term_q          = 8'd0;
        str_pos         = 16'd0;
        str_ended       = 1'b0;
        clear_escape();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_simple_escapes();
        test_escape_edges();
        test_random_strings();
        send_fragment();

        @(negedge clk);
        in_valid = 1'b0;
        while (decoded_q.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (err_count == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/esd_pkg.sv
hw/rtl/escape_sequence_decoder_core.sv
bench/tb_top.sv
